FILE: hw/rtl/rtf_picture_group_scanner_assert.svh
// Assertion macros shared by the scanner RTL.
`ifndef RTF_PICTURE_GROUP_SCANNER_ASSERT_SVH
`define RTF_PICTURE_GROUP_SCANNER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define RTFPGS_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define RTFPGS_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rtfpgs_pkg.sv
// Types, constants and per-byte judge function of the picture group scanner.
package rtfpgs_pkg;

  localparam int DEPTH_BITS  = 16;
  localparam int LENGTH_BITS = 24;
  localparam int RUN_BITS    = 8;
  localparam int THR_BITS    = 8;
  localparam int GROUP_LEN_W = 24;

  localparam int LA_BYTES    = 4;
  localparam int WIN_SLOTS   = LA_BYTES + 1;
  localparam int LA_IDX_BITS = $clog2(LA_BYTES);
  localparam int FILL_BITS   = $clog2(LA_BYTES + 1);
  localparam int CNT_BITS    = $clog2(WIN_SLOTS + 1);
  localparam int N_BITS      = $clog2(LA_BYTES + 1);

  typedef logic [7:0] byte_t;
  typedef logic [LA_BYTES-1:0][7:0] la_t;
  typedef logic [WIN_SLOTS-1:0][7:0] win_t;

  localparam byte_t CH_BACKSLASH = 8'h5C;
  localparam byte_t CH_LBRACE    = 8'h7B;
  localparam byte_t CH_RBRACE    = 8'h7D;
  localparam byte_t CH_P         = 8'h70;
  localparam byte_t CH_A         = 8'h61;
  localparam byte_t CH_R         = 8'h72;

  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 8'd32;

  typedef enum logic [1:0] {
    ST_CLOSED = 2'd0,
    ST_OPEN   = 2'd1,
    ST_ABORT  = 2'd2
  } status_t;

  typedef struct packed {
    byte_t text_char;
    logic  group_first;
    logic  text_last;
  } text_t;

  typedef struct packed {
    status_t                scan_status;
    logic                   hex_interrupted;
    logic                   nested_group_seen;
    logic [GROUP_LEN_W-1:0] group_length;
  } report_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0]  depth;
    logic [RUN_BITS-1:0]    run;
    logic                   in_hex;
    logic                   broken;
    logic                   intr;
    logic                   nested;
    logic [LENGTH_BITS-1:0] len;
  } scan_t;

  typedef struct packed {
    scan_t   st;
    logic    hit;
    status_t code;
  } judge_t;

  function automatic logic is_letter(byte_t c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_hex(byte_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_blank(byte_t c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  // Judge one byte against up to four following bytes (n of them known).
  function automatic judge_t judge_byte(scan_t s, byte_t c, la_t la,
                                        logic [N_BITS-1:0] n,
                                        logic [THR_BITS-1:0] thr);
    judge_t r;
    logic   par;
    r.st   = s;
    r.hit  = 1'b0;
    r.code = ST_OPEN;
    par = (c == CH_BACKSLASH) && (n >= N_BITS'(3)) && (la[0] == CH_P) &&
          (la[1] == CH_A) && (la[2] == CH_R) &&
          ((n < N_BITS'(LA_BYTES)) || !is_letter(la[3]));
    if (s.broken && (((c == CH_LBRACE) && (n >= N_BITS'(1)) &&
                      (la[0] == CH_BACKSLASH)) || par)) begin
      r.hit  = 1'b1;
      r.code = ST_ABORT;
    end else begin
      if (s.in_hex && c == CH_BACKSLASH) begin
        r.st.intr = 1'b1;
        if (par) begin
          r.st.broken = 1'b1;
        end
      end
      if (s.in_hex && c == CH_LBRACE) begin
        r.st.nested = 1'b1;
        r.st.broken = 1'b1;
      end
      if (c == CH_LBRACE) begin
        if (r.st.depth != '1) begin
          r.st.depth = r.st.depth + DEPTH_BITS'(1);
        end
      end else if (c == CH_RBRACE) begin
        if (r.st.depth != '0) begin
          r.st.depth = r.st.depth - DEPTH_BITS'(1);
        end
        if (r.st.depth == '0) begin
          r.hit  = 1'b1;
          r.code = ST_CLOSED;
        end
      end
      if (!r.hit && !r.st.broken) begin
        if (is_hex(c)) begin
          if (r.st.run != '1) begin
            r.st.run = r.st.run + RUN_BITS'(1);
          end
        end else if (!is_blank(c)) begin
          r.st.run    = '0;
          r.st.in_hex = 1'b0;
        end
        if (r.st.run >= thr) begin
          r.st.in_hex = 1'b1;
        end
      end
      if (r.st.len != '1) begin
        r.st.len = r.st.len + LENGTH_BITS'(1);
      end
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rtfpgs_judge_chain.sv
// Judge chain: up to five bytes of the window judged in order, combinationally.
module rtfpgs_judge_chain (
  input  rtfpgs_pkg::scan_t                     st_in,
  input  rtfpgs_pkg::win_t                      win,
  input  logic [rtfpgs_pkg::CNT_BITS-1:0]       count,
  input  logic                                  flush,
  input  logic [rtfpgs_pkg::THR_BITS-1:0]       thr,
  output rtfpgs_pkg::scan_t                     st_out,
  output logic                                  hit,
  output rtfpgs_pkg::status_t                   code
);
  import rtfpgs_pkg::*;

  logic [WIN_SLOTS+LA_BYTES-1:0][7:0] pad;
  la_t                                la;
  logic [N_BITS-1:0]                  n;
  judge_t                             jr;

  // Slot 0 is judged once the window is full; the text end judges every held slot.
  always_comb begin
    int avail;
    avail  = 0;
    st_out = st_in;
    hit    = 1'b0;
    code   = ST_OPEN;
    la     = '0;
    n      = '0;
    jr     = '0;
    pad    = '0;
    pad[WIN_SLOTS-1:0] = win;
    for (int j = 0; j < WIN_SLOTS; j++) begin
      for (int i = 0; i < LA_BYTES; i++) begin
        la[i] = pad[j + 1 + i];
      end
      avail = int'(count) - 1 - j;
      if (avail >= LA_BYTES) begin
        n = N_BITS'(LA_BYTES);
      end else if (avail > 0) begin
        n = N_BITS'(avail);
      end else begin
        n = '0;
      end
      jr = judge_byte(st_out, pad[j], la, n, thr);
      if (!hit && (j < int'(count)) &&
          (flush || (j == 0 && count == CNT_BITS'(WIN_SLOTS)))) begin
        st_out = jr.st;
        hit    = jr.hit;
        code   = jr.code;
      end
    end
  end

endmodule

FILE: hw/rtl/rtf_picture_group_scanner.sv
// Picture group scanner: walks one brace group of document text a byte at a
// time and reports how it ends.
//
// Channels: text_* carries one byte per transaction with group_first (the
// opening brace of a new scan) and text_last (end of the text). report_*
// carries one report per scan: status, the interrupted and nested flags and
// the group length. cfg_* writes hex_run_threshold and is always ready.
// Timing: a byte taken sits in the input register, is judged there and its
// report, if any, is registered in the report register. One byte is taken
// every cycle while no reporting byte is held (see Stall). A byte is judged
// with the four bytes behind it, so a closing brace reports four bytes after
// it arrives, or at text_last. The single stage holds a chain of up to five
// byte judgements, which is what sets the clock period at the end of the text.
// Stall: while a report waits, the input register still takes one byte and
// bytes that give no report keep flowing; a byte that would give a second
// report holds until the first is taken.
// Reset: synchronous; clears the scan, empties both registers and sets the threshold
// to 32. The user writes configuration only while the block is idle; it is not enforced.
`include "rtf_picture_group_scanner_assert.svh"

module rtf_picture_group_scanner (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtfpgs_pkg::THR_BITS-1:0]   cfg_data,
  input  logic                              text_valid,
  output logic                              text_ready,
  input  rtfpgs_pkg::text_t                 text_data,
  output logic                              report_valid,
  input  logic                              report_ready,
  output rtfpgs_pkg::report_t               report_data
);
  import rtfpgs_pkg::*;

  // Input register
  logic                  s1_valid;
  text_t                 s1_item;
  logic                  s1_advance;

  // Scan state
  logic [THR_BITS-1:0]   threshold;
  logic                  active;
  scan_t                 scan;
  byte_t                 la_bytes [LA_BYTES];
  logic [FILL_BITS-1:0]  fill;
  logic                  full;

  // Judge window and chain result
  win_t                  win;
  logic [CNT_BITS-1:0]   count;
  scan_t                 chain_st;
  logic                  chain_hit;
  status_t               chain_code;

  // Result
  logic                  res_hit;
  report_t               res;
  logic                  report_load;
  scan_t                 scan_start;

  assign cfg_ready = 1'b1;
  assign full      = (fill == FILL_BITS'(LA_BYTES));

  // Build the window: held bytes in order, then the incoming byte.
  always_comb begin
    win = '0;
    if (full) begin
      for (int i = 0; i < LA_BYTES; i++) begin
        win[i] = la_bytes[i];
      end
      win[LA_BYTES] = s1_item.text_char;
      count = CNT_BITS'(WIN_SLOTS);
    end else begin
      for (int i = 0; i < LA_BYTES; i++) begin
        if (i < int'(fill)) begin
          win[i] = la_bytes[i];
        end else if (i == int'(fill)) begin
          win[i] = s1_item.text_char;
        end
      end
      count = CNT_BITS'(fill) + CNT_BITS'(1);
    end
  end

  rtfpgs_judge_chain u_chain (
    .st_in  (scan),
    .win    (win),
    .count  (count),
    .flush  (s1_item.text_last),
    .thr    (threshold),
    .st_out (chain_st),
    .hit    (chain_hit),
    .code   (chain_code)
  );

  // Fresh scan: the marked byte is the opening brace, depth and length one.
  always_comb begin
    scan_start       = '0;
    scan_start.depth = DEPTH_BITS'(1);
    scan_start.len   = LENGTH_BITS'(1);
  end

  // Report for the byte in the input register, if it ends the scan.
  always_comb begin
    res     = '0;
    res_hit = 1'b0;
    res.scan_status = ST_OPEN;
    if (s1_item.group_first) begin
      res_hit = s1_item.text_last;
    end else if (active) begin
      res_hit               = chain_hit || s1_item.text_last;
      res.scan_status       = chain_hit ? chain_code : ST_OPEN;
      res.hex_interrupted   = chain_st.intr;
      res.nested_group_seen = chain_st.nested;
      if (chain_hit && chain_code == ST_CLOSED) begin
        res.group_length = GROUP_LEN_W'(chain_st.len);
      end
    end
  end

  // Advance unless this byte reports and the report register is still full.
  assign s1_advance  = s1_valid && (!res_hit || !report_valid || report_ready);
  assign report_load = s1_advance && res_hit;
  assign text_ready  = !s1_valid || s1_advance;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      threshold    <= THRESHOLD_RESET;
      active       <= 1'b0;
      scan         <= '0;
      fill         <= '0;
      report_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        threshold <= cfg_data;
      end
      if (text_ready) begin
        s1_valid <= text_valid;
      end
      if (s1_advance) begin
        if (s1_item.group_first) begin
          // Drop any scan in progress and start over.
          scan   <= scan_start;
          active <= !s1_item.text_last;
          fill   <= '0;
        end else if (active) begin
          scan <= chain_st;
          if (res_hit) begin
            active <= 1'b0;
            fill   <= '0;
          end else if (!full) begin
            fill <= fill + FILL_BITS'(1);
          end
        end
      end
      if (report_load) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (text_ready && text_valid) begin
      s1_item <= text_data;
    end
    if (s1_advance && active && !s1_item.group_first && !res_hit) begin
      if (full) begin
        // Slide the window by one byte.
        for (int i = 0; i < LA_BYTES; i++) begin
          la_bytes[i] <= win[i + 1];
        end
      end else begin
        la_bytes[fill[LA_IDX_BITS-1:0]] <= s1_item.text_char;
      end
    end
    if (report_load) begin
      report_data <= res;
    end
  end

  `RTFPGS_ASSERT_NOW(a_idle_window_empty, clk, rst, !active, fill == '0, "window holds bytes while idle")
  `RTFPGS_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FILL_BITS'(LA_BYTES), "window overfilled")
  `RTFPGS_ASSERT_NOW(a_no_overwrite, clk, rst, report_load && report_valid, report_ready, "report overwritten before taken")
  `RTFPGS_ASSERT_NEXT(a_report_shown, clk, rst, report_load, report_valid, "loaded report not shown")

endmodule
